[design/rth_pkg.sv]
// Shared types and constants for the RGB to HSL converter pipeline.
package rth_pkg;

    localparam int CHAN_W        = 8;
    localparam int FRAC_W        = 16;
    localparam int DIVISOR_W     = 11;
    localparam int DIV_BITS      = 16;
    localparam int STEPS_PER_STG = 4;
    localparam int DIV_STAGES    = DIV_BITS / STEPS_PER_STG;

    typedef logic [CHAN_W-1:0]    chan_t;
    typedef logic [FRAC_W-1:0]    frac_t;
    typedef logic [DIVISOR_W-1:0] divisor_t;

    // First stage: the channels plus their maximum and minimum.
    typedef struct packed {
        chan_t red;
        chan_t green;
        chan_t blue;
        chan_t hi;
        chan_t lo;
    } front_t;

    // State of one restoring divider: remainder, dividend bits still to
    // shift in, quotient so far and the divisor.
    typedef struct packed {
        divisor_t rem;
        frac_t    low;
        frac_t    quo;
        divisor_t divisor;
    } div_t;

    typedef struct packed {
        div_t  hue_div;
        div_t  sat_div;
        frac_t lightness;
        logic  hue_undefined;
    } pipe_t;

endpackage

[design/rth_front.sv]
// Front stages: max/min search, then hue numerator, divisors and lightness.
module rth_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  rth_pkg::chan_t  in_red,
    input  rth_pkg::chan_t  in_green,
    input  rth_pkg::chan_t  in_blue,
    output logic            out_valid,
    input  logic            out_ready,
    output rth_pkg::pipe_t  out_data
);

    logic            v1_reg;
    logic            v2_reg;
    logic            rdy1;
    logic            rdy2;
    rth_pkg::front_t d1_reg;
    rth_pkg::front_t d1_next;
    rth_pkg::pipe_t  d2_reg;
    rth_pkg::pipe_t  d2_next;

    rth_pkg::chan_t  t_hi;
    rth_pkg::chan_t  t_lo;

    logic [8:0]      chroma6_ext;
    logic [7:0]      chroma;
    logic [8:0]      sum;
    logic [7:0]      den;
    logic [11:0]     num;
    logic [10:0]     six_c;
    logic [23:0]     sat_num;
    logic [16:0]     light_prod;

    assign rdy1     = ~v1_reg | rdy2;
    assign rdy2     = ~v2_reg | out_ready;
    assign in_ready = rdy1;

    always_comb begin
        t_hi = (in_red > in_green) ? in_red : in_green;
        t_hi = (t_hi > in_blue) ? t_hi : in_blue;
        t_lo = (in_red < in_green) ? in_red : in_green;
        t_lo = (t_lo < in_blue) ? t_lo : in_blue;
        d1_next.red   = in_red;
        d1_next.green = in_green;
        d1_next.blue  = in_blue;
        d1_next.hi    = t_hi;
        d1_next.lo    = t_lo;
    end

    always_comb begin
        chroma      = d1_reg.hi - d1_reg.lo;
        sum         = {1'b0, d1_reg.hi} + {1'b0, d1_reg.lo};
        chroma6_ext = 9'(chroma);
        six_c       = 11'({chroma6_ext, 2'b00}) + 11'({chroma6_ext, 1'b0});
        den         = (sum <= 9'd255) ? sum[7:0] : 8'(9'd510 - sum);

        // Hue numerator scaled by the chroma, always in [0, 6C).
        priority if (d1_reg.hi == d1_reg.red) begin
            if (d1_reg.green >= d1_reg.blue) begin
                num = 12'(d1_reg.green) - 12'(d1_reg.blue);
            end else begin
                num = 12'(six_c) + 12'(d1_reg.green) - 12'(d1_reg.blue);
            end
        end else if (d1_reg.hi == d1_reg.green) begin
            num = 12'({chroma, 1'b0}) + 12'(d1_reg.blue) - 12'(d1_reg.red);
        end else begin
            num = 12'({chroma, 2'b00}) + 12'(d1_reg.red) - 12'(d1_reg.green);
        end

        sat_num    = {chroma, 16'h0000} - 24'(chroma);
        // 65535 / 510 is exactly 257 / 2.
        light_prod = {sum, 8'h00} + 17'(sum);

        d2_next.lightness     = light_prod[16:1];
        d2_next.hue_undefined = (chroma == 8'd0);

        d2_next.hue_div.low = '0;
        d2_next.hue_div.quo = '0;
        d2_next.sat_div.low = sat_num[15:0];
        d2_next.sat_div.quo = '0;
        if (chroma == 8'd0) begin
            // Grey: divide zero by one so both quotients come out zero.
            d2_next.hue_div.rem     = '0;
            d2_next.hue_div.divisor = 11'd1;
            d2_next.sat_div.rem     = '0;
            d2_next.sat_div.divisor = 11'd1;
        end else begin
            d2_next.hue_div.rem     = num[10:0];
            d2_next.hue_div.divisor = six_c;
            d2_next.sat_div.rem     = 11'(sat_num[23:16]);
            d2_next.sat_div.divisor = 11'(den);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else begin
            if (rdy1) begin
                v1_reg <= in_valid;
            end
            if (rdy2) begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy1 && in_valid) begin
            d1_reg <= d1_next;
        end
        if (rdy2 && v1_reg) begin
            d2_reg <= d2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_data  = d2_reg;

endmodule

[design/rth_div_stage.sv]
// One registered stage of the two restoring dividers, a few quotient bits each.
module rth_div_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           in_valid,
    output logic           in_ready,
    input  rth_pkg::pipe_t in_data,
    output logic           out_valid,
    input  logic           out_ready,
    output rth_pkg::pipe_t out_data
);

    logic           valid_reg;
    rth_pkg::pipe_t data_reg;
    rth_pkg::pipe_t data_next;

    function automatic rth_pkg::div_t div_step(input rth_pkg::div_t d);
        rth_pkg::div_t              r;
        logic [rth_pkg::DIVISOR_W:0] t;
        logic                        ge;
        t  = {d.rem, d.low[rth_pkg::FRAC_W-1]};
        ge = (t >= {1'b0, d.divisor});
        r  = d;
        r.rem = ge ? rth_pkg::DIVISOR_W'(t - {1'b0, d.divisor})
                   : t[rth_pkg::DIVISOR_W-1:0];
        r.low = {d.low[rth_pkg::FRAC_W-2:0], 1'b0};
        r.quo = {d.quo[rth_pkg::FRAC_W-2:0], ge};
        return r;
    endfunction

    always_comb begin
        data_next = in_data;
        for (int i = 0; i < rth_pkg::STEPS_PER_STG; i++) begin
            data_next.hue_div = div_step(data_next.hue_div);
            data_next.sat_div = div_step(data_next.sat_div);
        end
    end

    assign in_ready = ~valid_reg | out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[design/rgb_to_hsl_converter_top.sv]
// Top level of the RGB to HSL converter: front stages and divider pipeline.
//
//  Channel | Direction | tdata                               | tuser
//  s_axis  | in        | red[7:0] green[15:8] blue[23:16]    | -
//  m_axis  | out       | hue[15:0] sat[31:16] light[47:32]   | hue_undefined[0]
//
// One word per cycle enters and leaves while m_axis_tready is high; each word
// passes two front stages and four divider stages, each divider stage resolving
// four quotient bits of the hue and saturation dividers side by side.
// Reset clears only the valid bits of the stages.
// Every stage holds its word while the next one is full and stalled, so empty
// stages still fill up while the output waits.
module rgb_to_hsl_converter_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // red, green, blue
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // hue, saturation, lightness
    output logic [0:0]  m_axis_tuser    // hue_undefined
);

    logic           stg_valid [rth_pkg::DIV_STAGES+1];
    logic           stg_ready [rth_pkg::DIV_STAGES+1];
    rth_pkg::pipe_t stg_data  [rth_pkg::DIV_STAGES+1];

    rth_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_red    (s_axis_tdata[7:0]),
        .in_green  (s_axis_tdata[15:8]),
        .in_blue   (s_axis_tdata[23:16]),
        .out_valid (stg_valid[0]),
        .out_ready (stg_ready[0]),
        .out_data  (stg_data[0])
    );

    for (genvar k = 0; k < rth_pkg::DIV_STAGES; k++) begin : g_div
        rth_div_stage u_div (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[k]),
            .in_ready  (stg_ready[k]),
            .in_data   (stg_data[k]),
            .out_valid (stg_valid[k+1]),
            .out_ready (stg_ready[k+1]),
            .out_data  (stg_data[k+1])
        );
    end

    assign stg_ready[rth_pkg::DIV_STAGES] = m_axis_tready;
    assign m_axis_tvalid = stg_valid[rth_pkg::DIV_STAGES];
    assign m_axis_tdata  = {stg_data[rth_pkg::DIV_STAGES].lightness,
                            stg_data[rth_pkg::DIV_STAGES].sat_div.quo,
                            stg_data[rth_pkg::DIV_STAGES].hue_div.quo};
    assign m_axis_tuser  = stg_data[rth_pkg::DIV_STAGES].hue_undefined;

endmodule
